// ===== rtl/core/sensor_quality_rank_select_assert.svh =====
// Assertion macros used by the rank-select checker.
`ifndef SENSOR_QUALITY_RANK_SELECT_ASSERT_SVH
`define SENSOR_QUALITY_RANK_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQRS_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sqrs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQRS_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sqrs: next-cycle check failed");

`endif

// ===== rtl/core/sqrs_pkg.sv =====
// Shared constants, entry layout and control types of the rank-select block.
`default_nettype none

package sqrs_pkg;

    localparam int MAX_SENSORS = 8;
    localparam int IDX_W       = $clog2(MAX_SENSORS);
    localparam int CNT_W       = $clog2(MAX_SENSORS + 1);
    localparam int COORD_W     = 32;
    localparam int Q_W         = 8;
    localparam int AVAIL_W     = 4;
    localparam int SUM_W       = COORD_W + CNT_W;
    localparam int PROD_W      = COORD_W + CNT_W + 1;
    localparam int DIFF_W      = PROD_W + 1;
    localparam int DEV_W       = DIFF_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [Q_W-1:0]     quality;
        logic signed [COORD_W-1:0] speed;
        logic        [DEV_W-1:0]   dev;
    } entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DEV,
        ST_PASS_INIT,
        ST_SCAN,
        ST_SWAP,
        ST_AVAIL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             load;
        logic             dev_wr;
        logic             pass_init;
        logic             scan;
        logic             swap;
        logic             emit;
        logic             last;
        logic             clear;
        logic [IDX_W-1:0] addr;
        logic [CNT_W-1:0] avail;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             rd_good;
        logic             better;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sqrs_ctrl.sv =====
// Sequencer for load, deviation, selection sort, count and emit phases.
`default_nettype none

module sqrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last_sensor,
    input  sqrs_pkg::status_t  status,
    output logic               busy,
    output sqrs_pkg::cmd_t     cmd
);
    import sqrs_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic [CNT_W-1:0] avail_reg, avail_next;

    logic accept;
    logic idx_last;
    logic avail_go;

    assign accept   = start && (state_reg == ST_LOAD);
    assign idx_last = (idx_reg == (status.n - CNT_W'(1)));
    assign avail_go = (idx_reg < status.n) &&
                      (status.rd_good || (idx_reg < (status.n >> 1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
            pass_reg  <= '0;
            avail_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            avail_reg <= avail_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (accept && last_sensor)
                    state_next = ST_DEV;
            ST_DEV:
                if (idx_last)
                    state_next = (status.n == CNT_W'(1)) ? ST_AVAIL : ST_PASS_INIT;
            ST_PASS_INIT:
                state_next = ST_SCAN;
            ST_SCAN:
                if (idx_last)
                    state_next = ST_SWAP;
            ST_SWAP:
                state_next = ((pass_reg + CNT_W'(2)) == status.n) ? ST_AVAIL : ST_PASS_INIT;
            ST_AVAIL:
                if (!avail_go)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (idx_last)
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Index, pass and available-count registers.
    always_comb
    begin
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        avail_next = avail_reg;
        case (state_reg)
            ST_LOAD:
            begin
                idx_next  = '0;
                pass_next = '0;
            end
            ST_DEV:
                idx_next = idx_last ? CNT_W'(1) : idx_reg + CNT_W'(1);
            ST_PASS_INIT:
                idx_next = pass_reg + CNT_W'(1);
            ST_SCAN:
                if (!idx_last)
                    idx_next = idx_reg + CNT_W'(1);
            ST_SWAP:
            begin
                pass_next = pass_reg + CNT_W'(1);
                idx_next  = CNT_W'(1);
            end
            ST_AVAIL:
                if (avail_go)
                    idx_next = idx_reg + CNT_W'(1);
                else
                begin
                    avail_next = idx_reg;
                    idx_next   = '0;
                end
            ST_EMIT:
                idx_next = idx_reg + CNT_W'(1);
            default:
                idx_next = '0;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.addr  = idx_reg[IDX_W-1:0];
        cmd.avail = avail_reg;
        case (state_reg)
            ST_LOAD:
                cmd.load = accept;
            ST_DEV:
                cmd.dev_wr = 1'b1;
            ST_PASS_INIT:
            begin
                cmd.pass_init = 1'b1;
                cmd.addr      = pass_reg[IDX_W-1:0];
            end
            ST_SCAN:
                cmd.scan = 1'b1;
            ST_SWAP:
            begin
                cmd.swap = 1'b1;
                cmd.addr = pass_reg[IDX_W-1:0];
            end
            ST_AVAIL:
                cmd.addr = idx_reg[IDX_W-1:0];
            ST_EMIT:
            begin
                cmd.emit  = 1'b1;
                cmd.last  = idx_last;
                cmd.clear = idx_last;
            end
            default:
                cmd.addr = idx_reg[IDX_W-1:0];
        endcase
    end

    assign busy = (state_reg != ST_LOAD);

endmodule

`default_nettype wire

// ===== rtl/core/sqrs_datapath.sv =====
// Entry file, running sums, deviation unit, sort compare and result register.
`default_nettype none

module sqrs_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sqrs_pkg::cmd_t                       cmd,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  point_x,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  point_y,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  point_z,
    input  logic        [sqrs_pkg::Q_W-1:0]      quality,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  speed,
    output sqrs_pkg::status_t                    status,
    output logic                                 out_valid,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_x,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_y,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_z,
    output logic        [sqrs_pkg::Q_W-1:0]      out_quality,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_speed,
    output logic        [sqrs_pkg::AVAIL_W-1:0]  avail_count,
    output logic                                 last_out
);
    import sqrs_pkg::*;

    entry_t entry_mem [MAX_SENSORS];

    logic        [CNT_W-1:0] loaded_reg;
    logic        [CNT_W-1:0] good_cnt_reg;
    logic signed [SUM_W-1:0] good_sum_reg;
    logic                    valid_reg;

    entry_t           best_reg;
    entry_t           cur_reg;
    logic [IDX_W-1:0] best_idx_reg;

    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg, speed_reg;
    logic        [Q_W-1:0]     quality_reg;
    logic        [AVAIL_W-1:0] avail_reg;
    logic                      last_reg;

    entry_t                    rd;
    logic signed [COORD_W-1:0] rd_speed;
    logic signed [CNT_W:0]     gc_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [DIFF_W-1:0]  diff;
    logic        [DEV_W-1:0]   dev_calc;
    logic                      room;
    logic        [IDX_W-1:0]   load_idx;

    assign rd       = entry_mem[cmd.addr];
    assign rd_speed = rd.speed;
    assign room     = (loaded_reg < CNT_W'(MAX_SENSORS));
    assign load_idx = loaded_reg[IDX_W-1:0];

    // |count*speed - sum|, zero when no reading is usable
    assign gc_s     = $signed({1'b0, good_cnt_reg});
    assign prod     = gc_s * rd_speed;
    assign diff     = DIFF_W'(prod) - DIFF_W'(good_sum_reg);
    assign dev_calc = (good_cnt_reg == '0) ? '0 :
                      diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);

    assign status.n       = loaded_reg;
    assign status.rd_good = (rd.quality != '0);
    assign status.better  = (rd.quality > best_reg.quality) ||
                            ((rd.quality == best_reg.quality) && (rd.dev < best_reg.dev));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            good_cnt_reg <= '0;
            good_sum_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.clear)
            begin
                loaded_reg   <= '0;
                good_cnt_reg <= '0;
                good_sum_reg <= '0;
            end
            else if (cmd.load && room)
            begin
                loaded_reg <= loaded_reg + CNT_W'(1);
                if (quality != '0)
                begin
                    good_cnt_reg <= good_cnt_reg + CNT_W'(1);
                    good_sum_reg <= good_sum_reg + SUM_W'(speed);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            entry_mem[load_idx].x       <= point_x;
            entry_mem[load_idx].y       <= point_y;
            entry_mem[load_idx].z       <= point_z;
            entry_mem[load_idx].quality <= quality;
            entry_mem[load_idx].speed   <= speed;
        end
        if (cmd.dev_wr)
            entry_mem[cmd.addr].dev <= dev_calc;
        if (cmd.pass_init)
        begin
            best_reg     <= rd;
            cur_reg      <= rd;
            best_idx_reg <= cmd.addr;
        end
        if (cmd.scan && status.better)
        begin
            best_reg     <= rd;
            best_idx_reg <= cmd.addr;
        end
        // Swap only when the pass found a better entry further on.
        if (cmd.swap && (best_idx_reg != cmd.addr))
        begin
            entry_mem[best_idx_reg] <= cur_reg;
            entry_mem[cmd.addr]     <= best_reg;
        end
        if (cmd.emit)
        begin
            x_reg       <= rd.x;
            y_reg       <= rd.y;
            z_reg       <= rd.z;
            quality_reg <= rd.quality;
            speed_reg   <= rd.speed;
            avail_reg   <= AVAIL_W'(cmd.avail);
            last_reg    <= cmd.last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_z       = z_reg;
    assign out_quality = quality_reg;
    assign out_speed   = speed_reg;
    assign avail_count = avail_reg;
    assign last_out    = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sensor_quality_rank_select.sv =====
// Top level of the sensor quality rank-select block.
`default_nettype none

// Load readings one word per cycle with start while busy is low; the word
// that carries last_sensor closes the set and raises busy. Up to
// MAX_SENSORS readings are kept; extra readings are dropped, though their
// last_sensor flag still closes the set. The block then computes the speed
// deviations, runs the selection sort (skipped for a single reading), finds
// the available count and reads the results out. The sort is the long
// pole: each pass walks the remaining entries one per cycle through a
// single read port of the entry file. Results come out back to back, each
// shown for exactly one cycle with out_valid high; the receiver cannot
// stall, so capture every word on the cycle it shows. last_out marks the
// final word, and busy drops in that same cycle, so the next set may start
// loading right away.
module sensor_quality_rank_select (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  point_x,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  point_y,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  point_z,
    input  logic        [sqrs_pkg::Q_W-1:0]      quality,
    input  logic signed [sqrs_pkg::COORD_W-1:0]  speed,
    input  logic                                 last_sensor,
    output logic                                 out_valid,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_x,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_y,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_z,
    output logic        [sqrs_pkg::Q_W-1:0]      out_quality,
    output logic signed [sqrs_pkg::COORD_W-1:0]  out_speed,
    output logic        [sqrs_pkg::AVAIL_W-1:0]  avail_count,
    output logic                                 last_out
);
    import sqrs_pkg::*;

    // Commands from the sequencer, status back from the datapath.
    cmd_t    cmd;
    status_t status;

    sqrs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_sensor (last_sensor),
        .status      (status),
        .busy        (busy),
        .cmd         (cmd)
    );

    // Entry file, sums, deviation and compare logic, result register.
    sqrs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .quality     (quality),
        .speed       (speed),
        .status      (status),
        .out_valid   (out_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_quality (out_quality),
        .out_speed   (out_speed),
        .avail_count (avail_count),
        .last_out    (last_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sqrs_checker.sv =====
// Port-level checker for the rank-select block and its bind.
`default_nettype none
`include "sensor_quality_rank_select_assert.svh"

module sqrs_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               last_sensor,
    input  logic                               out_valid,
    input  logic                               last_out,
    input  logic [sqrs_pkg::AVAIL_W-1:0]       avail_count
);

    // A closing word must lock out further loads.
    `SQRS_ASSERT_NEXT(a_close_busy, clk, rst_n, start && !busy && last_sensor, busy)
    // Results of one set run back to back with one count.
    `SQRS_ASSERT_NEXT(a_burst, clk, rst_n, out_valid && !last_out, out_valid && $stable(avail_count))
    // Only the final result may show once loading reopens.
    `SQRS_ASSERT_IMPLY(a_mid_busy, clk, rst_n, out_valid && !last_out, busy)
    `SQRS_ASSERT_IMPLY(a_end_free, clk, rst_n, out_valid && last_out, !busy)

endmodule

bind sensor_quality_rank_select sqrs_checker u_sqrs_checker (.*);

`default_nettype wire

// ===== test/tb_sensor_quality_rank_select.sv =====
// Self-checking testbench for the sensor quality rank-select block.
`timescale 1ns / 1ps

// One sorted word as the block shows it on its result ports.
typedef struct packed {
    logic signed [sqrs_pkg::COORD_W-1:0] x;
    logic signed [sqrs_pkg::COORD_W-1:0] y;
    logic signed [sqrs_pkg::COORD_W-1:0] z;
    logic        [sqrs_pkg::Q_W-1:0]     quality;
    logic signed [sqrs_pkg::COORD_W-1:0] speed;
    logic        [sqrs_pkg::AVAIL_W-1:0] avail;
    logic                                last;
} ranked_word_t;

// Mirrors the set under construction and queues the sorted words it must produce.
class rank_select_board;
    sqrs_pkg::entry_t                    slots[sqrs_pkg::MAX_SENSORS];
    int unsigned                         loaded;
    logic [sqrs_pkg::CNT_W-1:0]          good_cnt;
    logic signed [sqrs_pkg::SUM_W-1:0]   good_sum;
    ranked_word_t                        sorted_words[$];
    int unsigned                         mismatches;
    int unsigned                         words_checked;
    int unsigned                         sets_closed;
    int unsigned                         dropped;

    function new();
        loaded        = 0;
        good_cnt      = '0;
        good_sum      = '0;
        mismatches    = 0;
        words_checked = 0;
        sets_closed   = 0;
        dropped       = 0;
    endfunction

    function int unsigned pending();
        return sorted_words.size();
    endfunction

    // Store a reading unless the set is full; a last flag closes the set either way.
    function void note_reading(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz, logic [7:0] q,
                               logic signed [31:0] spd, logic last);
        if (loaded < sqrs_pkg::MAX_SENSORS) begin
            slots[loaded].x       = px;
            slots[loaded].y       = py;
            slots[loaded].z       = pz;
            slots[loaded].quality = q;
            slots[loaded].speed   = spd;
            slots[loaded].dev     = '0;
            if (q != 0) begin
                good_cnt = good_cnt + 1'b1;
                good_sum = good_sum + spd;
            end
            loaded++;
        end
        else begin
            dropped++;
        end
        if (last)
            rank_and_emit();
    endfunction

    // Deviation, selection sort, available count, then queue one word per entry.
    function void rank_and_emit();
        sqrs_pkg::entry_t                   tmp;
        logic signed [sqrs_pkg::DIFF_W-1:0] diff;
        ranked_word_t                       w;
        int unsigned                        n, i, j, best, avail;
        n = loaded;
        for (i = 0; i < n; i++) begin
            if (good_cnt == 0) begin
                slots[i].dev = '0;
            end
            else begin
                diff = $signed({1'b0, good_cnt}) * $signed(slots[i].speed) - good_sum;
                if (diff < 0)
                    diff = -diff;
                slots[i].dev = diff;
            end
        end
        for (i = 0; i < n; i++) begin
            best = i;
            for (j = i + 1; j < n; j++) begin
                if (slots[j].quality > slots[best].quality ||
                    (slots[j].quality == slots[best].quality &&
                     slots[j].dev < slots[best].dev))
                    best = j;
            end
            if (best != i) begin
                tmp         = slots[i];
                slots[i]    = slots[best];
                slots[best] = tmp;
            end
        end
        avail = 1;
        while (avail < n && (slots[avail].quality != 0 || avail < n / 2))
            avail++;
        for (i = 0; i < n; i++) begin
            w.x       = slots[i].x;
            w.y       = slots[i].y;
            w.z       = slots[i].z;
            w.quality = slots[i].quality;
            w.speed   = slots[i].speed;
            w.avail   = avail[sqrs_pkg::AVAIL_W-1:0];
            w.last    = (i + 1 == n);
            sorted_words.push_back(w);
        end
        loaded   = 0;
        good_cnt = '0;
        good_sum = '0;
        sets_closed++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Check one result word against the oldest queued word.
    function void check_word(ranked_word_t got);
        ranked_word_t want;
        if (sorted_words.size() == 0) begin
            $display("%0t: unexpected result word: x %h quality %h last %b",
                     $time, got.x, got.quality, got.last);
            mismatches++;
            return;
        end
        want = sorted_words.pop_front();
        words_checked++;
        compare_field("out_x", want.x, got.x);
        compare_field("out_y", want.y, got.y);
        compare_field("out_z", want.z, got.z);
        compare_field("out_quality", 32'(want.quality), 32'(got.quality));
        compare_field("out_speed", want.speed, got.speed);
        compare_field("avail_count", 32'(want.avail), 32'(got.avail));
        compare_field("last_out", 32'(want.last), 32'(got.last));
    endfunction
endclass

module tb_sensor_quality_rank_select;
    import sqrs_pkg::*;

    // Any quiet stretch far beyond the time a full set takes from its closing
    // word to its final result, plus the longest sender gap, means the block
    // has hung.
    localparam int QUIET_LIMIT     = 2000;
    // Hold this long after the last result so a stray extra word shows up.
    localparam int DRAIN_CYCLES    = 80;
    localparam int RANDOM_READINGS = 200;
    // Readings at the end of the run that are sent back to back.
    localparam int SMOOTH_TAIL     = 40;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       start       = 1'b0;
    logic signed [COORD_W-1:0]  point_x     = '0;
    logic signed [COORD_W-1:0]  point_y     = '0;
    logic signed [COORD_W-1:0]  point_z     = '0;
    logic        [Q_W-1:0]      quality     = '0;
    logic signed [COORD_W-1:0]  speed       = '0;
    logic                       last_sensor = 1'b0;
    logic                       busy;
    logic                       out_valid;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic        [Q_W-1:0]      out_quality;
    logic signed [COORD_W-1:0]  out_speed;
    logic        [AVAIL_W-1:0]  avail_count;
    logic                       last_out;

    rank_select_board board;
    bit               gaps_on;
    int unsigned      quiet_cycles;

    sensor_quality_rank_select i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .quality     (quality),
        .speed       (speed),
        .last_sensor (last_sensor),
        .out_valid   (out_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_quality (out_quality),
        .out_speed   (out_speed),
        .avail_count (avail_count),
        .last_out    (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sample both sides at the rising edge, before the block's own updates
    // land. A word is taken when start is high and busy is low; a result is
    // taken whenever out_valid is high, since the receiver never stalls.
    always @(posedge clk)
    begin
        ranked_word_t seen;
        if (rst_n) begin
            if (start && !busy)
                board.note_reading(point_x, point_y, point_z, quality, speed, last_sensor);
            if (out_valid) begin
                seen.x       = out_x;
                seen.y       = out_y;
                seen.z       = out_z;
                seen.quality = out_quality;
                seen.speed   = out_speed;
                seen.avail   = avail_count;
                seen.last    = last_out;
                board.check_word(seen);
            end
            // Count cycles in which neither side moves a word.
            if ((start && !busy) || out_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog expired with %0d words still due",
                         $time, board.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Hold start low and scramble the payload, so that only the handshake
    // decides what the block takes.
    task automatic idle_inputs(int unsigned cycles);
        repeat (cycles) begin
            start       <= 1'b0;
            point_x     <= $urandom;
            point_y     <= $urandom;
            point_z     <= $urandom;
            quality     <= 8'($urandom_range(0, 255));
            speed       <= $urandom;
            last_sensor <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
    endtask

    // Offer one reading and hold it until the block takes it. Start may rise
    // while busy is high; the block must simply leave the word waiting.
    task automatic send_reading(logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz, logic [7:0] q,
                                logic signed [31:0] spd, logic last);
        if (gaps_on && $urandom_range(0, 3) == 0)
            idle_inputs($urandom_range(1, 16));
        start       <= 1'b1;
        point_x     <= px;
        point_y     <= py;
        point_z     <= pz;
        quality     <= q;
        speed       <= spd;
        last_sensor <= last;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start and wait until every queued word has come out.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // One set of random readings with the last flag on the final one. Bias
    // the quality toward zero and toward one shared score, and the speed
    // toward the extremes and toward one shared value, so that ties in
    // quality and in deviation come up often.
    task automatic send_random_set(int unsigned count);
        logic [7:0]         tie_q;
        logic [7:0]         q;
        logic signed [31:0] base_speed;
        logic signed [31:0] spd;
        int unsigned        pick;
        tie_q      = 8'($urandom_range(1, 255));
        base_speed = $urandom;
        for (int unsigned i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                q = '0;
            else if (pick < 6)
                q = tie_q;
            else
                q = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            case (pick)
                0:       spd = 32'h7FFF_FFFF;
                1:       spd = 32'h8000_0000;
                2, 3, 4: spd = base_speed + 32'($urandom_range(0, 64)) - 32'sd32;
                5:       spd = base_speed;
                default: spd = $urandom;
            endcase
            send_reading($urandom, $urandom, $urandom, q, spd, i == count - 1);
        end
    endtask

    initial
    begin
        int unsigned stored;
        int unsigned size;
        board        = new();
        gaps_on      = 1'b0;
        quiet_cycles = 0;
        stored       = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single reading with no usable quality: every deviation is zero.
        send_reading(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'd0,
                     32'h7FFF_FFFF, 1'b1);
        // Single reading at the top score and the most negative speed.
        send_reading(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd255,
                     32'h8000_0000, 1'b1);

        // Full set: quality ties broken by deviation, speeds at both ends so
        // the deviation reaches its widest.
        gaps_on = 1'b1;
        send_reading($urandom, $urandom, $urandom, 8'd5,   32'h7FFF_FFFF, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd255, 32'h8000_0000, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd5,   32'h0000_0000, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0,   32'h0000_3039, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd255, 32'h8000_0000, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd5,   32'hFFFF_FFFF, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0,   32'h7FFF_FFFF, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd1,   32'h0000_0064, 1'b1);

        // Overflowing set: three good readings mixed with zeros to fill it, then
        // two high-quality readings that must be dropped, the second of
        // which still closes the set. The count advances past the zeros
        // until it reaches half the set.
        gaps_on = 1'b0;
        send_reading($urandom, $urandom, $urandom, 8'd9,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd9,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd3,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0,   $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd255, $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd255, $urandom, 1'b1);

        // Set with no usable reading at all: the count stays at one.
        send_reading($urandom, $urandom, $urandom, 8'd0, $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0, $urandom, 1'b0);
        send_reading($urandom, $urandom, $urandom, 8'd0, $urandom, 1'b1);

        // Hold off the sender until the block has emptied.
        drain_results();

        // Random sets, mostly within capacity, some overflowing. Idle in
        // bursts on most sets, and not at all in the closing stretch.
        while (stored < RANDOM_READINGS) begin
            if ($urandom_range(0, 7) == 0)
                size = $urandom_range(MAX_SENSORS + 1, MAX_SENSORS + 3);
            else
                size = $urandom_range(1, MAX_SENSORS);
            if (stored + SMOOTH_TAIL >= RANDOM_READINGS)
                gaps_on = 1'b0;
            else
                gaps_on = ($urandom_range(0, 2) != 0);
            send_random_set(size);
            stored += (size > MAX_SENSORS) ? MAX_SENSORS : size;
            if (!gaps_on && stored + SMOOTH_TAIL < RANDOM_READINGS &&
                $urandom_range(0, 9) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Closed %0d sets and checked %0d sorted words; %0d readings dropped.",
                 board.sets_closed, board.words_checked, board.dropped);
        $display("Covered single, full, overflowing and all-unusable sets with idling.");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
